### rtl/rpq_pkg.sv
package rpq_pkg;

   localparam int LANES_DEF     = 8;
   localparam int MAX_DISKS_DEF = 255;

   localparam logic [7:0] GF_POLY_LOW = 8'h71;

   localparam logic [7:0] CSR_MODE        = 8'd0;
   localparam logic [7:0] CSR_DISK_COUNT  = 8'd1;
   localparam logic [7:0] CSR_LOST_FIRST  = 8'd2;
   localparam logic [7:0] CSR_LOST_SECOND = 8'd3;

   localparam logic MODE_GENERATE = 1'b0;
   localparam logic MODE_RECOVER  = 1'b1;

   typedef logic [7:0] rpq_tbl_type [256];

   typedef struct packed {
      logic accum;
      logic fin_mul;
      logic fin_load;
   } rpq_cmd_type;

   function automatic logic [7:0] gf_mulx(input logic [7:0] a);
      gf_mulx = {a[6:0], 1'b0} ^ (a[7] ? GF_POLY_LOW : 8'h00);
   endfunction

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] prod;
      prod = 8'h00;
      for (int i = 7; i >= 0; i--) begin
         prod = gf_mulx(prod);
         if (b[i]) begin
            prod = prod ^ a;
         end
      end
      return prod;
   endfunction

   function automatic logic [7:0] gf_inv(input logic [7:0] a);
      logic [7:0] z;
      logic [7:0] y;
      z = gf_mul(a, a);
      y = z;
      for (int i = 0; i < 6; i++) begin
         z = gf_mul(z, z);
         y = gf_mul(y, z);
      end
      return y;
   endfunction

   function automatic rpq_tbl_type build_pow();
      rpq_tbl_type t;
      t[0] = 8'h01;
      for (int e = 1; e < 256; e++) begin
         t[e] = gf_mulx(t[e-1]);
      end
      return t;
   endfunction

   function automatic rpq_tbl_type build_xneg();
      rpq_tbl_type p;
      rpq_tbl_type t;
      p = build_pow();
      t[0] = p[0];
      for (int i = 1; i < 256; i++) begin
         t[i] = p[255 - i];
      end
      return t;
   endfunction

   function automatic rpq_tbl_type build_den();
      rpq_tbl_type p;
      rpq_tbl_type t;
      p = build_pow();
      for (int d = 0; d < 256; d++) begin
         t[d] = gf_inv(8'h01 ^ p[d]);
      end
      return t;
   endfunction

   localparam rpq_tbl_type POW_TBL  = build_pow();
   localparam rpq_tbl_type XNEG_TBL = build_xneg();
   localparam rpq_tbl_type DEN_TBL  = build_den();

   function automatic logic [63:0] lane_mask(input int lanes);
      logic [63:0] m;
      m = '0;
      for (int i = 0; i < 8; i++) begin
         if (i < lanes) begin
            m[8*i +: 8] = 8'hFF;
         end
      end
      return m;
   endfunction

   function automatic logic [63:0] word_mul(input logic [63:0] w, input logic [7:0] c);
      logic [63:0] r;
      for (int i = 0; i < 8; i++) begin
         r[8*i +: 8] = gf_mul(w[8*i +: 8], c);
      end
      return r;
   endfunction

endpackage

### rtl/rpq_ctrl.sv
module rpq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic                 req_tlast,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output rpq_pkg::rpq_cmd_type cmd
);
   import rpq_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_MUL  = 4'b0010,
      ST_LOAD = 4'b0100,
      ST_SEND = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tlast) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL:  state_in = ST_LOAD;
         ST_LOAD: state_in = ST_SEND;
         ST_SEND: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready   = (state_ff == ST_IDLE);
   assign rsp_tvalid   = (state_ff == ST_SEND);
   assign cmd.accum    = req_tready && req_tvalid;
   assign cmd.fin_mul  = (state_ff == ST_MUL);
   assign cmd.fin_load = (state_ff == ST_LOAD);

endmodule

### rtl/rpq_dp.sv
module rpq_dp #(
   parameter int LANES     = rpq_pkg::LANES_DEF,
   parameter int MAX_DISKS = rpq_pkg::MAX_DISKS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  rpq_pkg::rpq_cmd_type cmd,
   input  logic                 csr_valid,
   input  logic [7:0]           csr_index,
   input  logic [7:0]           csr_data,
   input  logic [79:0]          req_tdata,
   output logic [127:0]         rsp_tdata,
   output logic                 rsp_tuser
);
   import rpq_pkg::*;

   localparam logic [63:0] MASK = lane_mask(LANES);
   localparam logic [7:0]  NMAX = 8'(MAX_DISKS);

   logic        mode_ff;
   logic [7:0]  disk_count_ff;
   logic [7:0]  lost_first_ff;
   logic [7:0]  lost_second_ff;
   logic [63:0] p_sum_ff, q_sum_ff, p_st_ff, q_st_ff, t_ff;
   logic [63:0] p_sum_in, q_sum_in, p_st_in, q_st_in;
   logic [63:0] first_ff, second_ff;
   logic        status_ff;

   logic [63:0] w;
   logic [8:0]  slot;
   logic [7:0]  n;
   logic [7:0]  lo, hi;
   logic        bad;
   logic        is_lost;
   logic [63:0] dp, dq, db;

   assign w    = req_tdata[63:0] & MASK;
   assign slot = req_tdata[72:64];
   assign n    = (disk_count_ff > NMAX) ? NMAX : disk_count_ff;
   assign lo   = (lost_first_ff < lost_second_ff) ? lost_first_ff : lost_second_ff;
   assign hi   = (lost_first_ff < lost_second_ff) ? lost_second_ff : lost_first_ff;
   assign bad  = (lo == hi) || (hi >= n);
   assign is_lost = (slot == {1'b0, lost_first_ff}) || (slot == {1'b0, lost_second_ff});
   assign dp   = p_st_ff ^ p_sum_ff;
   assign dq   = q_st_ff ^ q_sum_ff;
   assign db   = word_mul(t_ff, DEN_TBL[hi - lo]) & MASK;

   always_comb begin
      p_sum_in = p_sum_ff;
      q_sum_in = q_sum_ff;
      p_st_in  = p_st_ff;
      q_st_in  = q_st_ff;
      if (cmd.accum) begin
         if (slot < {1'b0, n}) begin
            if (!(mode_ff == MODE_RECOVER && is_lost)) begin
               p_sum_in = p_sum_ff ^ w;
               q_sum_in = q_sum_ff ^ (word_mul(w, POW_TBL[slot[7:0]]) & MASK);
            end
         end else if (mode_ff == MODE_RECOVER && slot == {1'b0, n}) begin
            p_st_in = w;
         end else if (mode_ff == MODE_RECOVER && slot == ({1'b0, n} + 9'd1)) begin
            q_st_in = w;
         end
      end else if (cmd.fin_load) begin
         p_sum_in = '0;
         q_sum_in = '0;
         p_st_in  = '0;
         q_st_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_GENERATE;
         disk_count_ff  <= 8'd8;
         lost_first_ff  <= 8'd0;
         lost_second_ff <= 8'd1;
         p_sum_ff       <= '0;
         q_sum_ff       <= '0;
         p_st_ff        <= '0;
         q_st_ff        <= '0;
      end else begin
         p_sum_ff <= p_sum_in;
         q_sum_ff <= q_sum_in;
         p_st_ff  <= p_st_in;
         q_st_ff  <= q_st_in;
         if (csr_valid) begin
            case (csr_index)
               CSR_MODE:        mode_ff        <= csr_data[0];
               CSR_DISK_COUNT:  disk_count_ff  <= csr_data;
               CSR_LOST_FIRST:  lost_first_ff  <= csr_data;
               CSR_LOST_SECOND: lost_second_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.fin_mul) begin
         t_ff <= dp ^ (word_mul(dq, XNEG_TBL[lo]) & MASK);
      end
      if (cmd.fin_load) begin
         if (mode_ff == MODE_GENERATE) begin
            first_ff  <= p_sum_ff;
            second_ff <= q_sum_ff;
            status_ff <= 1'b0;
         end else if (bad) begin
            first_ff  <= '0;
            second_ff <= '0;
            status_ff <= 1'b1;
         end else begin
            first_ff  <= (dp ^ db) & MASK;
            second_ff <= db;
            status_ff <= 1'b0;
         end
      end
   end

   assign rsp_tdata = {second_ff, first_ff};
   assign rsp_tuser = status_ff;

endmodule

### rtl/raid6_pq_syndrome_and_recovery.sv
// Channel  Direction  Beat contents
// req      in         tdata: column_word[63:0], slot[72:64], zeros; tlast: last
// rsp      out        tdata: first_word[63:0], second_word[127:64]; tuser: status
// csr      in         csr_index: register index; csr_data: value
// An item without last is accumulated and the next can follow at once.
// An item with last is followed by the finishing multiplies in the MUL and LOAD states through
// the per-lane GF(2^8) constant multipliers, then the result beat is offered.
// No new item is taken until the result beat is accepted.
// Synchronous active-high reset restores the register defaults and clears the accumulators.
module raid6_pq_syndrome_and_recovery #(
   parameter int LANES     = rpq_pkg::LANES_DEF,
   parameter int MAX_DISKS = rpq_pkg::MAX_DISKS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [79:0]  req_tdata,   // column_word, slot
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,   // first_word, second_word
   output logic         rsp_tuser,   // status
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [7:0]   csr_index,
   input  logic [7:0]   csr_data
);
   import rpq_pkg::*;

   rpq_cmd_type cmd;

   assign csr_ready = 1'b1;

   rpq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   rpq_dp #(
      .LANES     (LANES),
      .MAX_DISKS (MAX_DISKS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .csr_valid (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

`ifndef SYNTHESIS
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("input taken while a result is pending");
   a_ready_after_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready |=> req_tready)
      else $error("input not reopened after result beat");
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("error result carries data");
`endif

endmodule
